>>> rtl/core/tsce_pkg.sv
// ----------------------------------------------------------------------------
// tsce_pkg
// Shared types and codes of the server connection engine.
// ----------------------------------------------------------------------------
`default_nettype none

package tsce_pkg;

    typedef enum logic [2:0] {
        OP_OPEN    = 3'd0,
        OP_ACCEPT  = 3'd1,
        OP_SEGMENT = 3'd2,
        OP_CONSUME = 3'd3,
        OP_CLOSE   = 3'd4,
        OP_EXPIRE  = 3'd5
    } t_op;

    typedef enum logic [2:0] {
        SEG_SYN     = 3'd0,
        SEG_SYNACK  = 3'd1,
        SEG_FIN     = 3'd2,
        SEG_FINACK  = 3'd3,
        SEG_DATA    = 3'd4,
        SEG_DATAACK = 3'd5
    } t_seg;

    typedef enum logic [1:0] {
        CONN_CLOSED    = 2'd0,
        CONN_LISTENING = 2'd1,
        CONN_CONNECTED = 2'd2,
        CONN_CLOSEWAIT = 2'd3
    } t_conn;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_FAIL      = 2'd1,
        STAT_NO_MATCH  = 2'd2,
        STAT_NOT_READY = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        RPL_SYNACK  = 2'd0,
        RPL_DATAACK = 2'd1,
        RPL_FINACK  = 2'd2
    } t_rpl;

    typedef struct packed {
        logic [2:0]  op;
        logic [2:0]  slot;
        logic [15:0] server_port;
        logic [2:0]  seg_type;
        logic [15:0] seg_src_port;
        logic [15:0] seg_dest_port;
        logic [7:0]  seg_src_node;
        logic [31:0] seg_seq;
        logic [12:0] seg_length;
        logic [16:0] take_length;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  slot_out;
        logic [1:0]  conn_state;
        logic        reply_valid;
        logic [1:0]  reply_type;
        logic [15:0] reply_src_port;
        logic [15:0] reply_dest_port;
        logic [7:0]  reply_dest_node;
        logic [31:0] reply_ack;
    } t_rsp;

endpackage

`default_nettype wire

>>> rtl/core/tsce_req_if.sv
// ----------------------------------------------------------------------------
// tsce_req_if
// Command channel: valid, ready and one command request.
// ----------------------------------------------------------------------------
`default_nettype none

interface tsce_req_if
    import tsce_pkg::*;
;
    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/tsce_rsp_if.sv
// ----------------------------------------------------------------------------
// tsce_rsp_if
// Result channel: valid, ready and one result.
// ----------------------------------------------------------------------------
`default_nettype none

interface tsce_rsp_if
    import tsce_pkg::*;
;
    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/tsce_ram.sv
// ----------------------------------------------------------------------------
// tsce_ram
// Simple dual-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tsce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire                                   i_clk,
    input  wire                                   i_we,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]                      i_wdata,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

`default_nettype wire

>>> rtl/core/transport_server_connection_engine.sv
// ----------------------------------------------------------------------------
// transport_server_connection_engine
// Server connection table: open, accept, segment, consume, close, expiry.
// ----------------------------------------------------------------------------
// Slot commands go from accept through S_LOAD and S_EXEC to the output register.
// Open and segment scan the table RAM one entry a cycle in S_SCAN, stopping at the
// first in-use slot whose port matches or after the last slot, then go to S_EXEC.
// One command is in flight at a time; the next is taken when the last is written
// to the output register. Synchronous active-low reset empties the table.
`default_nettype none

module transport_server_connection_engine
    import tsce_pkg::*;
#(
    parameter int SLOTS        = 8,
    parameter int BUFFER_BYTES = 65536
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    tsce_req_if.sink    i_req,
    tsce_rsp_if.source  o_rsp
);
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int FW = $clog2(BUFFER_BYTES);
    localparam int EW = FW + 74;
    localparam int SW = ((FW > 13) ? FW : 13) + 1;
    localparam int CW = (FW > 17) ? FW : 17;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_LOAD = 4'b0100,
        S_EXEC = 4'b1000
    } t_fsm;

    t_fsm             r_state;
    t_req             r_req;
    logic             r_ok;
    logic             r_hit;
    logic [IW-1:0]    r_idx;
    logic [IW-1:0]    r_sel;
    logic [EW-1:0]    r_ent;
    logic [SLOTS-1:0] r_in_use;
    logic             r_ovalid;
    t_rsp             r_rsp;

    logic [EW-1:0]    w_rdata;
    logic [EW-1:0]    w_wdata;
    logic [IW-1:0]    w_raddr;
    logic [IW-1:0]    w_waddr;
    logic             w_we;
    logic             w_accept;
    logic             w_fire;
    logic [IW+2:0]    w_slot_x;
    logic             w_addr_ok;
    logic             w_scan_hit;
    logic [15:0]      w_scan_port;
    logic [IW-1:0]    w_free_idx;
    logic             w_free_any;
    logic             w_set;
    logic             w_clr;
    t_rsp             w_rsp;

    // entry fields
    logic [FW-1:0]    e_fill;
    logic [31:0]      e_exp;
    logic [7:0]       e_node;
    logic [15:0]      e_peer;
    logic [1:0]       e_st;
    logic [15:0]      e_bound;
    logic [FW-1:0]    n_fill;
    logic [31:0]      n_exp;
    logic [7:0]       n_node;
    logic [15:0]      n_peer;
    logic [1:0]       n_st;
    logic [15:0]      n_bound;

    assign e_fill  = r_ent[FW-1:0];
    assign e_exp   = r_ent[FW+31:FW];
    assign e_node  = r_ent[FW+39:FW+32];
    assign e_peer  = r_ent[FW+55:FW+40];
    assign e_st    = r_ent[FW+57:FW+56];
    assign e_bound = r_ent[FW+73:FW+58];
    assign w_wdata = {n_bound, n_st, n_peer, n_node, n_exp, n_fill};

    tsce_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_tsce_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_fire      = (r_state == S_EXEC) && (!r_ovalid || o_rsp.ready);
    assign o_rsp.valid = r_ovalid;
    assign o_rsp.data  = r_rsp;

    assign w_slot_x  = {{IW{1'b0}}, i_req.data.slot};
    assign w_addr_ok = (w_slot_x < (IW+3)'(SLOTS)) && r_in_use[w_slot_x[IW-1:0]];

    always_comb begin
        if (r_state == S_SCAN) begin
            w_raddr = r_idx + IW'(1);
        end else if (i_req.data.op == OP_OPEN || i_req.data.op == OP_SEGMENT) begin
            w_raddr = '0;
        end else begin
            w_raddr = w_slot_x[IW-1:0];
        end
    end

    assign w_scan_port = (r_req.op == OP_OPEN) ? r_req.server_port : r_req.seg_dest_port;
    assign w_scan_hit  = r_in_use[r_idx] && (w_rdata[FW+73:FW+58] == w_scan_port);

    // lowest free slot
    always_comb begin
        w_free_idx = '0;
        w_free_any = 1'b0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_in_use[i]) begin
                w_free_idx = IW'(i);
                w_free_any = 1'b1;
            end
        end
    end

    always_comb begin
        logic          peer;
        logic [SW-1:0] sum;
        logic [CW-1:0] fill_x;
        logic [CW-1:0] take_x;
        logic          show;
        logic          reply;
        logic [1:0]    rtype;
        logic [31:0]   ack;
        logic [IW+2:0] sel_x;

        peer   = (e_peer == r_req.seg_src_port) && (e_node == r_req.seg_src_node);
        sum    = SW'(e_fill) + SW'(r_req.seg_length);
        fill_x = CW'(e_fill);
        take_x = CW'(r_req.take_length);
        show   = 1'b0;
        reply  = 1'b0;
        rtype  = RPL_SYNACK;
        ack    = '0;
        sel_x  = {3'b000, r_sel};

        n_fill  = e_fill;
        n_exp   = e_exp;
        n_node  = e_node;
        n_peer  = e_peer;
        n_st    = e_st;
        n_bound = e_bound;
        w_we    = 1'b0;
        w_waddr = r_sel;
        w_set   = 1'b0;
        w_clr   = 1'b0;
        w_rsp   = '0;
        w_rsp.status = STAT_FAIL;

        case (r_req.op)
            OP_OPEN: begin
                if (!r_hit && w_free_any) begin
                    n_bound = r_req.server_port;
                    n_st    = CONN_CLOSED;
                    n_fill  = '0;
                    n_exp   = '0;
                    n_node  = '0;
                    n_peer  = '0;
                    w_we    = 1'b1;
                    w_waddr = w_free_idx;
                    w_set   = 1'b1;
                    sel_x   = {3'b000, w_free_idx};
                    show    = 1'b1;
                    w_rsp.status = STAT_OK;
                end
            end
            OP_ACCEPT: begin
                if (r_ok) begin
                    show = 1'b1;
                    if (e_st == CONN_CLOSED) begin
                        n_st = CONN_LISTENING;
                        w_we = 1'b1;
                        w_rsp.status = STAT_NOT_READY;
                    end
                end
            end
            OP_SEGMENT: begin
                if (!r_hit) begin
                    w_rsp.status = STAT_NO_MATCH;
                end else begin
                    show = 1'b1;
                    if (e_st == CONN_LISTENING) begin
                        if (r_req.seg_type == SEG_SYN) begin
                            n_node = r_req.seg_src_node;
                            n_peer = r_req.seg_src_port;
                            n_exp  = r_req.seg_seq;
                            n_st   = CONN_CONNECTED;
                            reply  = 1'b1;
                        end
                    end else if (e_st == CONN_CONNECTED && peer) begin
                        if (r_req.seg_type == SEG_SYN) begin
                            n_exp = r_req.seg_seq;
                            reply = 1'b1;
                        end else if (r_req.seg_type == SEG_DATA) begin
                            rtype = RPL_DATAACK;
                            if (r_req.seg_seq == e_exp) begin
                                if (sum < SW'(BUFFER_BYTES)) begin
                                    n_fill = sum[FW-1:0];
                                    n_exp  = r_req.seg_seq + 32'(r_req.seg_length);
                                    reply  = 1'b1;
                                end
                            end else begin
                                reply = 1'b1;
                            end
                            ack = n_exp;
                        end else if (r_req.seg_type == SEG_FIN) begin
                            n_st  = CONN_CLOSEWAIT;
                            rtype = RPL_FINACK;
                            reply = 1'b1;
                        end
                    end else if (e_st == CONN_CLOSEWAIT && peer
                                 && r_req.seg_type == SEG_FIN) begin
                        rtype = RPL_FINACK;
                        reply = 1'b1;
                    end
                    w_we = reply;
                end
            end
            OP_CONSUME: begin
                if (r_ok) begin
                    show = 1'b1;
                    if (e_st == CONN_CONNECTED) begin
                        if (fill_x >= take_x) begin
                            n_fill = FW'(fill_x - take_x);
                            w_we   = 1'b1;
                            w_rsp.status = STAT_OK;
                        end else begin
                            w_rsp.status = STAT_NOT_READY;
                        end
                    end
                end
            end
            OP_CLOSE: begin
                if (r_ok) begin
                    show = 1'b1;
                    if (e_st == CONN_CLOSED) begin
                        w_clr = 1'b1;
                        w_rsp.status = STAT_OK;
                    end
                end
            end
            OP_EXPIRE: begin
                if (r_ok) begin
                    show = 1'b1;
                    if (e_st == CONN_CLOSEWAIT) begin
                        n_fill = '0;
                        n_st   = CONN_CLOSED;
                        w_we   = 1'b1;
                        w_rsp.status = STAT_OK;
                    end
                end
            end
            default: begin
            end
        endcase

        if (show) begin
            w_rsp.slot_out   = sel_x[2:0];
            w_rsp.conn_state = n_st;
        end
        if (reply) begin
            w_rsp.status          = STAT_OK;
            w_rsp.reply_valid     = 1'b1;
            w_rsp.reply_type      = rtype;
            w_rsp.reply_src_port  = n_bound;
            w_rsp.reply_dest_port = n_peer;
            w_rsp.reply_dest_node = n_node;
            w_rsp.reply_ack       = ack;
        end
        // hold the table until the result can be stored
        if (!w_fire) begin
            w_we  = 1'b0;
            w_set = 1'b0;
            w_clr = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_in_use <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_req <= i_req.data;
                        r_ok  <= w_addr_ok;
                        r_sel <= w_slot_x[IW-1:0];
                        r_idx <= '0;
                        r_hit <= 1'b0;
                        if (i_req.data.op == OP_OPEN || i_req.data.op == OP_SEGMENT) begin
                            r_state <= S_SCAN;
                        end else begin
                            r_state <= S_LOAD;
                        end
                    end
                end
                S_SCAN: begin
                    if (w_scan_hit) begin
                        r_hit   <= 1'b1;
                        r_ent   <= w_rdata;
                        r_sel   <= r_idx;
                        r_state <= S_EXEC;
                    end else if (r_idx == IW'(SLOTS - 1)) begin
                        r_state <= S_EXEC;
                    end else begin
                        r_idx <= r_idx + IW'(1);
                    end
                end
                S_LOAD: begin
                    r_ent   <= w_rdata;
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    if (w_fire) begin
                        r_rsp    <= w_rsp;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                        if (w_set) begin
                            r_in_use[w_free_idx] <= 1'b1;
                        end
                        if (w_clr) begin
                            r_in_use[r_sel] <= 1'b0;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule

`default_nettype wire

>>> rtl/core/tsce_checker.sv
// ----------------------------------------------------------------------------
// tsce_checker
// Port-level checks on the result channel of the connection engine.
// ----------------------------------------------------------------------------
`default_nettype none

module tsce_checker
    import tsce_pkg::*;
(
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_valid,
    input wire       i_ready,
    input wire t_rsp i_rsp
);
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !i_valid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_rsp))
        else $error("stalled result changed");

    a_no_reply_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_rsp.reply_valid |-> i_rsp.reply_type == 2'd0
            && i_rsp.reply_ack == 32'd0 && i_rsp.reply_src_port == 16'd0
            && i_rsp.reply_dest_port == 16'd0 && i_rsp.reply_dest_node == 8'd0)
        else $error("reply fields set without reply");

    a_reply_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_rsp.reply_valid |-> i_rsp.status == STAT_OK
            && (i_rsp.reply_type == RPL_DATAACK || i_rsp.reply_ack == 32'd0))
        else $error("reply with bad status or ack");

    a_no_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_rsp.status == STAT_NO_MATCH |-> !i_rsp.reply_valid
            && i_rsp.slot_out == 3'd0 && i_rsp.conn_state == CONN_CLOSED)
        else $error("unmatched segment reports a slot");
endmodule

bind transport_server_connection_engine tsce_checker u_tsce_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_rsp.valid),
    .i_ready (o_rsp.ready),
    .i_rsp   (o_rsp.data)
);

`default_nettype wire
